// ----- design/ssme_pkg.sv -----
// Shared types, operation codes and controller interface for the sorted set merge engine.
`timescale 1ns / 1ps
package ssme_pkg;

	// Operation mode codes
	localparam logic [2:0] MODE_LOAD   = 3'd0;
	localparam logic [2:0] MODE_UNION  = 3'd1;
	localparam logic [2:0] MODE_INTER  = 3'd2;
	localparam logic [2:0] MODE_DIFF   = 3'd3;
	localparam logic [2:0] MODE_SUBSET = 3'd4;
	localparam logic [2:0] MODE_QUERY  = 3'd5;
	localparam logic [2:0] MODE_CLEAR  = 3'd6;

	typedef struct packed {
		logic signed [31:0] element;
		logic               last_element;
	} in_t;

	typedef struct packed {
		logic [8:0] cardinality;
		logic       in_set;
		logic       is_subset;
		logic       overflow;
		logic       order_error;
	} out_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_eval;
		logic copy_wr;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic copy_needed;
		logic copy_last;
	} status_t;

endpackage

// ----- design/ssme_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module ssme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/ssme_datapath.sv -----
// Datapath: operand and set stores, merge buffer, scan counters, merge decision, result register.
`timescale 1ns / 1ps
module ssme_datapath #(
	parameter int SET_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_wdata,
	input  ssme_pkg::in_t    in_data,
	input  ssme_pkg::cmd_t   cmd,
	output ssme_pkg::status_t status,
	output ssme_pkg::out_t   out_data
);

	localparam int AW = $clog2(SET_DEPTH);
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

	logic [2:0]         mode_q;
	logic [CW-1:0]      set_cnt_q, op_cnt_q, i_q, j_q, n_q, k_q;
	logic signed [31:0] prev_q, elem_q;
	logic               have_prev_q, sticky_q, last_q, oerr_q, member_q, subset_q;
	ssme_pkg::out_t     out_q;

	logic [31:0]        set_rdata, op_rdata, mbuf_rdata;
	logic signed [31:0] a, b, emit_val;
	logic               a_v, b_v, query, in_err, op_we;
	logic               done, adv_i, adv_j, emit, set_ovf, set_sub, set_mem;
	logic [CW-1:0]      new_cnt;

	assign query  = (mode_q == ssme_pkg::MODE_QUERY);
	assign in_err = have_prev_q && (in_data.element <= prev_q);
	assign op_we  = cmd.accept && !query && !in_err && (op_cnt_q < DEPTH_C);
	assign a      = $signed(set_rdata);
	assign b      = $signed(op_rdata);
	assign a_v    = (i_q < set_cnt_q);
	assign b_v    = (j_q < op_cnt_q);

	ssme_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_op_ram (
		.clk  (clk),
		.we   (op_we),
		.waddr(op_cnt_q[AW-1:0]),
		.wdata(in_data.element),
		.raddr(j_q[AW-1:0]),
		.rdata(op_rdata)
	);

	ssme_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_set_ram (
		.clk  (clk),
		.we   (cmd.copy_wr),
		.waddr(k_q[AW-1:0]),
		.wdata(mbuf_rdata),
		.raddr(i_q[AW-1:0]),
		.rdata(set_rdata)
	);

	ssme_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_mbuf_ram (
		.clk  (clk),
		.we   (cmd.scan_eval && emit),
		.waddr(n_q[AW-1:0]),
		.wdata(emit_val),
		.raddr(k_q[AW-1:0]),
		.rdata(mbuf_rdata)
	);

	// Decide one merge or lookup step from the current pair of words
	always_comb begin
		done     = 1'b0;
		adv_i    = 1'b0;
		adv_j    = 1'b0;
		emit     = 1'b0;
		emit_val = a;
		set_ovf  = 1'b0;
		set_sub  = 1'b0;
		set_mem  = 1'b0;
		case (mode_q)
			ssme_pkg::MODE_LOAD: begin
				if (!b_v) begin
					done = 1'b1;
				end else begin
					emit     = 1'b1;
					emit_val = b;
					adv_j    = 1'b1;
				end
			end
			ssme_pkg::MODE_UNION: begin
				if (!a_v && !b_v) begin
					done = 1'b1;
				end else if (n_q == DEPTH_C) begin
					done    = 1'b1;
					set_ovf = 1'b1;
				end else begin
					emit = 1'b1;
					if (!b_v || (a_v && a < b)) begin
						adv_i = 1'b1;
					end else if (!a_v || b < a) begin
						emit_val = b;
						adv_j    = 1'b1;
					end else begin
						adv_i = 1'b1;
						adv_j = 1'b1;
					end
				end
			end
			ssme_pkg::MODE_INTER: begin
				if (!a_v || !b_v) begin
					done = 1'b1;
				end else if (a < b) begin
					adv_i = 1'b1;
				end else if (a > b) begin
					adv_j = 1'b1;
				end else begin
					emit  = 1'b1;
					adv_i = 1'b1;
					adv_j = 1'b1;
				end
			end
			ssme_pkg::MODE_DIFF: begin
				if (!a_v) begin
					done = 1'b1;
				end else if (!b_v || a < b) begin
					emit  = 1'b1;
					adv_i = 1'b1;
				end else if (a > b) begin
					adv_j = 1'b1;
				end else begin
					adv_i = 1'b1;
					adv_j = 1'b1;
				end
			end
			ssme_pkg::MODE_SUBSET: begin
				if (!a_v) begin
					done    = 1'b1;
					set_sub = 1'b1;
				end else if (!b_v || a < b) begin
					done = 1'b1;
				end else if (a > b) begin
					adv_j = 1'b1;
				end else begin
					adv_i = 1'b1;
					adv_j = 1'b1;
				end
			end
			ssme_pkg::MODE_QUERY: begin
				if (!a_v) begin
					done = 1'b1;
				end else if (a == elem_q) begin
					done    = 1'b1;
					set_mem = 1'b1;
				end else begin
					adv_i = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Set size once the operation completes
	always_comb begin
		new_cnt = set_cnt_q;
		if (last_q && !query) begin
			case (mode_q)
				ssme_pkg::MODE_LOAD, ssme_pkg::MODE_UNION,
				ssme_pkg::MODE_INTER, ssme_pkg::MODE_DIFF: new_cnt = n_q;
				ssme_pkg::MODE_CLEAR: new_cnt = '0;
				default: new_cnt = set_cnt_q;
			endcase
		end
	end

	// Status towards the controller
	always_comb begin
		status.need_scan   = query || (in_data.last_element && (mode_q <= ssme_pkg::MODE_SUBSET));
		status.scan_done   = done;
		status.copy_needed = (mode_q <= ssme_pkg::MODE_DIFF) && (n_q != '0);
		status.copy_last   = ((k_q + CW'(1)) >= n_q);
	end

	// Control registers: counters, flags, mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ssme_pkg::MODE_LOAD;
			set_cnt_q   <= '0;
			op_cnt_q    <= '0;
			have_prev_q <= 1'b0;
			sticky_q    <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
			oerr_q      <= 1'b0;
			member_q    <= 1'b0;
			subset_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			// Take the beat: order check and buffering
			if (cmd.accept) begin
				i_q      <= '0;
				j_q      <= '0;
				n_q      <= '0;
				k_q      <= '0;
				member_q <= 1'b0;
				subset_q <= 1'b0;
				last_q   <= in_data.last_element;
				oerr_q   <= !query && in_err;
				if (!query && !in_err) begin
					have_prev_q <= 1'b1;
					if (op_cnt_q < DEPTH_C) begin
						op_cnt_q <= op_cnt_q + CW'(1);
					end else begin
						sticky_q <= 1'b1;
					end
				end
			end
			// Advance the scan
			if (cmd.scan_eval) begin
				if (adv_i) i_q <= i_q + CW'(1);
				if (adv_j) j_q <= j_q + CW'(1);
				if (emit)  n_q <= n_q + CW'(1);
				if (set_ovf) sticky_q <= 1'b1;
				if (set_sub) subset_q <= 1'b1;
				if (set_mem) member_q <= 1'b1;
			end
			if (cmd.copy_wr) begin
				k_q <= k_q + CW'(1);
			end
			// Commit the set size and, after a last beat outside query mode, drop the operand buffer
			if (cmd.finish) begin
				set_cnt_q <= new_cnt;
				if (last_q && !query) begin
					sticky_q    <= 1'b0;
					op_cnt_q    <= '0;
					have_prev_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= in_data.element;
			if (!query && !in_err) begin
				prev_q <= in_data.element;
			end
		end
		if (cmd.finish) begin
			out_q.cardinality <= 9'(new_cnt);
			out_q.in_set      <= member_q;
			out_q.is_subset   <= subset_q;
			out_q.overflow    <= sticky_q;
			out_q.order_error <= oerr_q;
		end
	end

	assign out_data = out_q;

endmodule

// ----- design/ssme_ctrl.sv -----
// Controller state machine: handshakes, scan and copy sequencing.
`timescale 1ns / 1ps
module ssme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ssme_pkg::status_t status,
	output ssme_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN_RD = 3'd1;
	localparam logic [2:0] ST_SCAN_EV = 3'd2;
	localparam logic [2:0] ST_COPY_RD = 3'd3;
	localparam logic [2:0] ST_COPY_WR = 3'd4;
	localparam logic [2:0] ST_FIN     = 3'd5;
	localparam logic [2:0] ST_OUT     = 3'd6;

	logic [2:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.need_scan ? ST_SCAN_RD : ST_FIN;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				if (status.scan_done) begin
					state_d = status.copy_needed ? ST_COPY_RD : ST_FIN;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = status.copy_last ? ST_FIN : ST_COPY_RD;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

endmodule

// ----- design/sorted_set_merge_engine_core.sv -----
// Top level of the sorted set merge engine: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_data  (ssme_pkg::in_t)
//  out     | output    | out_valid / out_stall| out_data (ssme_pkg::out_t)
//  cfg     | input     | cfg_we               | cfg_wdata (operation mode)
//
// A beat that needs no scan goes through accept, finish, then the result state.
// A scan step is a registered RAM read, then a compare; a union takes up to
// |A|+|B|+1 steps, a load |B|+1, an intersection, difference or subset test at most
// |A|+|B|+1, and a copy from the merge buffer adds a read and a write per word.
// A query takes up to |A|+1 scan steps. One beat is in flight at a time.
// Reset clears counts and flags; store contents need no clearing.
// in_stall stays high from accept until the result beat leaves; out_data holds while stalled.
`timescale 1ns / 1ps
module sorted_set_merge_engine_core #(
	parameter int SET_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  ssme_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ssme_pkg::out_t out_data
);

	ssme_pkg::cmd_t    cmd;
	ssme_pkg::status_t status;

	ssme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ssme_datapath #(.SET_DEPTH(SET_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

	// No new beat while a result is pending
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input accepted while result pending");

	// Membership and subset answers never coincide
	a_member_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.in_set && out_data.is_subset))
		else $error("member and subset both set");

	// An order error comes only outside query mode
	a_oerr_no_member: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.order_error) |-> !out_data.in_set)
		else $error("order error on a query result");

	// A result is presented in the cycle after finishing
	a_fin_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("result not presented after finish");

endmodule

// ----- test/tb_sorted_set_merge_engine_core.sv -----
// Testbench for the sorted set merge engine: directed table, random set phases, scoreboard.
`timescale 1ns / 1ps
module tb_sorted_set_merge_engine_core;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 50000;
	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam logic [31:0] BIAS = 32'h8000_0000;

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [2:0] cfg_wdata;
	ssme_pkg::in_t in_data;
	ssme_pkg::out_t out_data;

	sorted_set_merge_engine_core #(.SET_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Predictor state, elements held as sign-flipped keys
	logic [31:0] a_keys [DEPTH];
	logic [31:0] b_keys [DEPTH];
	logic [31:0] merged [DEPTH];
	int a_cnt, b_cnt;
	logic [31:0] prev_key;
	logic have_prev, ovf_sticky;
	logic [2:0] cur_mode;

	ssme_pkg::out_t pending_q [$];
	int errors, beats_in, beats_out, quiet, idle_cycles, out_wait;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(string what);
		errors++;
		$display("mismatch on %s at %0t", what, $realtime);
	endtask

	function automatic ssme_pkg::out_t predict_step(ssme_pkg::in_t it);
		logic [31:0] key;
		ssme_pkg::out_t r;
		int i, j, n;
		logic [31:0] v;
		key = it.element ^ BIAS;
		r = '0;
		if (cur_mode == ssme_pkg::MODE_QUERY) begin
			for (i = 0; i < a_cnt; i++)
				if (a_keys[i] == key) r.in_set = 1;
			r.overflow = ovf_sticky;
		end else begin
			if (have_prev && key <= prev_key) begin
				r.order_error = 1;
			end else begin
				prev_key = key;
				have_prev = 1;
				if (b_cnt < DEPTH) b_keys[b_cnt++] = key;
				else ovf_sticky = 1;
			end
			if (it.last_element) begin
				i = 0; j = 0; n = 0;
				case (cur_mode)
					ssme_pkg::MODE_LOAD: begin
						for (i = 0; i < b_cnt; i++) a_keys[i] = b_keys[i];
						a_cnt = b_cnt;
					end
					ssme_pkg::MODE_UNION: begin
						while (i < a_cnt || j < b_cnt) begin
							if (j >= b_cnt || (i < a_cnt && a_keys[i] < b_keys[j])) v = a_keys[i++];
							else if (i >= a_cnt || b_keys[j] < a_keys[i]) v = b_keys[j++];
							else begin v = a_keys[i]; i++; j++; end
							if (n >= DEPTH) begin ovf_sticky = 1; break; end
							merged[n++] = v;
						end
						for (i = 0; i < n; i++) a_keys[i] = merged[i];
						a_cnt = n;
					end
					ssme_pkg::MODE_INTER: begin
						while (i < a_cnt && j < b_cnt) begin
							if (a_keys[i] < b_keys[j]) i++;
							else if (a_keys[i] > b_keys[j]) j++;
							else begin a_keys[n++] = a_keys[i]; i++; j++; end
						end
						a_cnt = n;
					end
					ssme_pkg::MODE_DIFF: begin
						while (i < a_cnt) begin
							if (j >= b_cnt || a_keys[i] < b_keys[j]) a_keys[n++] = a_keys[i++];
							else if (a_keys[i] > b_keys[j]) j++;
							else begin i++; j++; end
						end
						a_cnt = n;
					end
					ssme_pkg::MODE_SUBSET: begin
						r.is_subset = 1;
						while (i < a_cnt && j < b_cnt) begin
							if (a_keys[i] < b_keys[j]) begin r.is_subset = 0; break; end
							if (a_keys[i] > b_keys[j]) j++;
							else begin i++; j++; end
						end
						if (i != a_cnt) r.is_subset = 0;
					end
					ssme_pkg::MODE_CLEAR: a_cnt = 0;
					default: ;
				endcase
				r.overflow = ovf_sticky;
				ovf_sticky = 0;
				b_cnt = 0;
				have_prev = 0;
			end else begin
				r.overflow = ovf_sticky;
			end
		end
		r.cardinality = a_cnt[8:0];
		return r;
	endfunction

	// Drive one beat after a random gap; record its expected result on acceptance
	task automatic send(ssme_pkg::in_t it, bit typed, ssme_pkg::out_t typed_res);
		int gap;
		ssme_pkg::out_t res;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		in_data = it;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		res = predict_step(it);
		pending_q.push_back(typed ? typed_res : res);
		beats_in++;
		@(negedge clk);
	endtask

	// Wait until the block is idle, then write the mode register
	task automatic set_mode(logic [2:0] m);
		in_valid = 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 0;
		cur_mode = m;
	endtask

	task automatic send_set(int vals [$]);
		ssme_pkg::in_t it;
		ssme_pkg::out_t z;
		z = '0;
		foreach (vals[k]) begin
			it.element = vals[k];
			it.last_element = (k == vals.size() - 1);
			send(it, 0, z);
		end
	endtask

	// Result side: stall draw per beat, compare at the rising edge
	always @(negedge clk) begin
		if (out_wait > 0) begin
			out_stall <= 1;
			out_wait <= out_wait - 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		ssme_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			out_wait <= quiet ? 0 : $urandom_range(0, 4);
			if (pending_q.size() == 0) begin
				report("unexpected result beat");
			end else begin
				e = pending_q.pop_front();
				if (out_data.cardinality != e.cardinality) report("cardinality");
				if (out_data.in_set != e.in_set) report("in_set");
				if (out_data.is_subset != e.is_subset) report("is_subset");
				if (out_data.overflow != e.overflow) report("overflow");
				if (out_data.order_error != e.order_error) report("order_error");
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog expired");
			$display("FAIL sorted_set_merge_engine_core");
			$finish;
		end
	end

	typedef struct {
		logic [2:0] mode;
		int elem;
		bit last;
		bit typed;
		ssme_pkg::out_t res;
	} row_t;

	function automatic ssme_pkg::out_t mk(int card, bit mem, bit sub, bit ovf, bit oerr);
		ssme_pkg::out_t r;
		r.cardinality = card[8:0];
		r.in_set = mem;
		r.is_subset = sub;
		r.overflow = ovf;
		r.order_error = oerr;
		return r;
	endfunction

	initial begin
		row_t rows [$];
		int vals [$];
		int uniq [$];
		int n, pick;
		logic [2:0] m;
		ssme_pkg::in_t it;
		errors = 0; beats_in = 0; beats_out = 0; quiet = 0; idle_cycles = 0; out_wait = 0;
		a_cnt = 0; b_cnt = 0; prev_key = 0; have_prev = 0; ovf_sticky = 0;
		cur_mode = ssme_pkg::MODE_LOAD;
		arst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0; in_data = '0; out_stall = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, each mode, order error, leftover subset case
		rows = '{
			'{ssme_pkg::MODE_LOAD,   32'h8000_0000, 0, 1, mk(0, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_LOAD,   32'h7fff_ffff, 1, 1, mk(2, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_QUERY,  32'h8000_0000, 0, 1, mk(2, 1, 0, 0, 0)},
			'{ssme_pkg::MODE_QUERY,  0,             0, 1, mk(2, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_QUERY,  32'h7fff_ffff, 1, 1, mk(2, 1, 0, 0, 0)},
			'{ssme_pkg::MODE_SUBSET, 32'h8000_0000, 0, 1, mk(2, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_SUBSET, 32'h8000_0000, 0, 1, mk(2, 0, 0, 0, 1)},
			'{ssme_pkg::MODE_SUBSET, 32'h7fff_ffff, 1, 1, mk(2, 0, 1, 0, 0)},
			'{ssme_pkg::MODE_SUBSET, 5,             1, 1, mk(2, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_UNION,  -1,            0, 0, mk(0, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_UNION,  1,             1, 1, mk(4, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_INTER,  1,             1, 1, mk(1, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_DIFF,   1,             1, 1, mk(0, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_UNION,  7,             0, 0, mk(0, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_UNION,  3,             1, 1, mk(1, 0, 0, 0, 1)},
			'{MODE_SPARE,            9,             1, 1, mk(1, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_CLEAR,  0,             1, 1, mk(0, 0, 0, 0, 0)},
			'{ssme_pkg::MODE_QUERY,  0,             0, 1, mk(0, 0, 0, 0, 0)}
		};
		foreach (rows[r]) begin
			if (rows[r].mode != cur_mode) set_mode(rows[r].mode);
			it.element = rows[r].elem;
			it.last_element = rows[r].last;
			send(it, rows[r].typed, rows[r].res);
		end

		// Full store, then a union past the depth, then an operand overflow
		set_mode(ssme_pkg::MODE_LOAD);
		vals = {};
		for (int k = 0; k < DEPTH; k++) vals.push_back(k * 4);
		send_set(vals);
		set_mode(ssme_pkg::MODE_UNION);
		vals = '{-7, -3, 1, 2, 3};
		send_set(vals);
		set_mode(ssme_pkg::MODE_LOAD);
		vals = {};
		for (int k = 0; k < DEPTH + 3; k++) vals.push_back(k * 2 - 300);
		send_set(vals);

		// Random phases of well-formed sets with some noise
		while (beats_in < 700) begin
			quiet = ($urandom_range(0, 5) == 0);
			m = $urandom_range(0, 7);
			set_mode(m);
			for (int s = 0; s < $urandom_range(1, 3); s++) begin
				n = $urandom_range(1, 10);
				vals = {};
				for (int k = 0; k < n; k++) begin
					pick = $urandom_range(0, 3);
					if (pick == 0 && a_cnt > 0)
						vals.push_back(int'(a_keys[$urandom_range(0, a_cnt - 1)] ^ BIAS));
					else if (pick == 1)
						vals.push_back($urandom_range(0, 40) - 20);
					else
						vals.push_back(int'($urandom));
				end
				if (m != ssme_pkg::MODE_QUERY) begin
					vals.sort();
					uniq = {};
					foreach (vals[k])
						if (uniq.size() == 0 || uniq[$] != vals[k]) uniq.push_back(vals[k]);
					vals = uniq;
					// Occasionally break the order
					if ($urandom_range(0, 7) == 0 && vals.size() > 1)
						vals.insert($urandom_range(1, vals.size() - 1), vals[0]);
				end
				send_set(vals);
			end
		end

		in_valid = 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("sent %0d beats, checked %0d results over every mode,", beats_in, beats_out);
		$display("including full-store, union overflow and order errors; %0d mismatches", errors);
		if (errors == 0 && pending_q.size() == 0)
			$display("PASS sorted_set_merge_engine_core");
		else
			$display("FAIL sorted_set_merge_engine_core");
		$finish;
	end

endmodule

// ----- files.f -----
design/ssme_pkg.sv
design/ssme_ram.sv
design/ssme_datapath.sv
design/ssme_ctrl.sv
design/sorted_set_merge_engine_core.sv
test/tb_sorted_set_merge_engine_core.sv
